### rtl/prs_pkg.sv
// Shared types and constants for the PID regulator step block.
// Holds register indexes, fixed-point constants and the micro-op encoding.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package prs_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_PROP   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_INTEG  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_DERIV  = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL_US = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETPOINT    = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEADBAND    = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE_MIN   = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE_MAX   = 4'd7;

    // Fixed-point constants
    localparam logic [23:0] MICROS_PER_SEC = 24'd1000000;
    localparam logic [61:0] TERM_CLAMP     = 62'h2000_0000_0000_0000;
    localparam logic [31:0] DRIVE_POS_MAX  = 32'h7fff_ffff;
    localparam logic [31:0] DRIVE_NEG_MAX  = 32'h8000_0000;
    localparam logic [47:0] SUM_POS_MAX    = 48'h7fff_ffff_ffff;
    localparam logic [47:0] SUM_NEG_MAX    = 48'h8000_0000_0000;

    // Micro-ops of the shared 32x32 multiplier
    typedef enum logic [3:0] {
        OP_P,       // |Kp| * |e|
        OP_KI_IV,   // |Ki| * interval
        OP_I_00,    // partial products of (|Ki|*iv) * |sum|
        OP_I_01,
        OP_I_10,
        OP_I_11,
        OP_KD_US,   // |Kd| * 1e6
        OP_D_0,     // partial products of (|Kd|*1e6) * |diff|
        OP_D_1
    } op_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_32,
        SH_64
    } acc_shift_t;

    // Decoded control for one micro-op
    typedef struct packed {
        logic [31:0] mul_a;
        logic [31:0] mul_b;
        acc_shift_t  shift;
        logic        clear;
        logic        to_t;
        op_t         succ;
    } op_ctrl_t;

endpackage

`default_nettype wire

### rtl/pid_regulator_step.sv
// A new measurement is accepted only once the previous result is loaded into the output register.
// A shared 32x32 multiplier runs 9 micro-ops, each in a multiply then an accumulate state,
// and a radix-16 restoring divider serves the I and D terms (skipped if the term clamps).
// A finished result sits in the output register while the next item is accepted.
// Reset (synchronous, aresetn low) clears error sum, last error and last drive,
// and loads the configuration defaults; no clearing pass is needed.
//
// PID regulator step: deadband, anti-windup integral, derivative, Q16.16 saturated drive.
// Depends on prs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pid_regulator_step (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration write channel
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [prs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [31:0]                      cfg_data,
    // measurement input
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [31:0]               s_measured,
    // drive output
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [31:0]                    m_drive,
    output logic                                  m_in_deadband
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_SUM,
        ST_MAG,
        ST_MUL,
        ST_ACC,
        ST_DIV_INIT,
        ST_DIV,
        ST_TERM,
        ST_FIN
    } state_t;

    // configuration registers
    logic signed [31:0] gain_prop_reg, gain_integ_reg, gain_deriv_reg;
    logic        [23:0] interval_us_reg;
    logic signed [31:0] setpoint_reg;
    logic        [30:0] deadband_reg;
    logic signed [31:0] drive_min_reg, drive_max_reg;

    // regulator state
    logic signed [47:0] error_sum_reg;
    logic signed [31:0] last_error_reg;
    logic signed [31:0] last_drive_reg;

    // sequencer and datapath registers
    state_t             state_reg;
    prs_pkg::op_t       op_reg;
    logic signed [31:0] meas_reg;
    logic signed [31:0] e_reg;
    logic               inband_reg;
    logic               windup_ok_reg;
    logic signed [32:0] diff_reg;
    logic        [31:0] akp_reg, aki_reg, akd_reg, ae_reg, adiff_reg;
    logic        [47:0] asum_reg;
    logic        [23:0] iv_reg;
    logic               neg_p_reg, neg_i_reg, neg_d_reg;
    logic        [63:0] prod_reg;
    logic       [103:0] acc_reg;
    logic        [55:0] t_reg;
    logic        [23:0] div_d_reg;
    logic        [23:0] rem_reg;
    logic        [63:0] num_reg;
    logic        [63:0] quot_reg;
    logic               low_reg;
    logic               ovf_reg;
    logic        [3:0]  div_cnt_reg;
    logic signed [63:0] total_reg;
    logic               m_valid_reg;
    logic signed [31:0] drive_reg;
    logic               out_inband_reg;

    assign cfg_ready     = 1'b1;
    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_drive       = drive_reg;
    assign m_in_deadband = out_inband_reg;

    // configuration writes; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_prop_reg   <= '0;
            gain_integ_reg  <= '0;
            gain_deriv_reg  <= '0;
            interval_us_reg <= 24'd1;
            setpoint_reg    <= '0;
            deadband_reg    <= '0;
            drive_min_reg   <= prs_pkg::DRIVE_NEG_MAX;
            drive_max_reg   <= prs_pkg::DRIVE_POS_MAX;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                prs_pkg::CFG_GAIN_PROP:   gain_prop_reg   <= cfg_data;
                prs_pkg::CFG_GAIN_INTEG:  gain_integ_reg  <= cfg_data;
                prs_pkg::CFG_GAIN_DERIV:  gain_deriv_reg  <= cfg_data;
                prs_pkg::CFG_INTERVAL_US: interval_us_reg <= cfg_data[23:0];
                prs_pkg::CFG_SETPOINT:    setpoint_reg    <= cfg_data;
                prs_pkg::CFG_DEADBAND:    deadband_reg    <= cfg_data[30:0];
                prs_pkg::CFG_DRIVE_MIN:   drive_min_reg   <= cfg_data;
                prs_pkg::CFG_DRIVE_MAX:   drive_max_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // error, deadband test and 32-bit saturation
    logic signed [32:0] e_wide;
    logic        [32:0] e_mag;
    logic               inband_next;
    logic signed [31:0] e_next;

    always_comb begin
        e_wide      = {setpoint_reg[31], setpoint_reg} - {meas_reg[31], meas_reg};
        e_mag       = e_wide[32] ? 33'(-e_wide) : 33'(e_wide);
        inband_next = (e_mag < {2'b00, deadband_reg});
        if (inband_next) begin
            e_next = '0;
        end else if (e_wide[32] != e_wide[31]) begin
            e_next = e_wide[32] ? prs_pkg::DRIVE_NEG_MAX : prs_pkg::DRIVE_POS_MAX;
        end else begin
            e_next = e_wide[31:0];
        end
    end

    // saturated error sum and error difference
    logic signed [48:0] sum_wide;
    logic signed [47:0] sum_next;
    logic signed [32:0] diff_next;

    always_comb begin
        sum_wide = {error_sum_reg[47], error_sum_reg} + {{17{e_reg[31]}}, e_reg};
        if (sum_wide[48] != sum_wide[47]) begin
            sum_next = sum_wide[48] ? prs_pkg::SUM_NEG_MAX : prs_pkg::SUM_POS_MAX;
        end else begin
            sum_next = sum_wide[47:0];
        end
        diff_next = {e_reg[31], e_reg} - {last_error_reg[31], last_error_reg};
    end

    // micro-op decode for the shared multiplier
    prs_pkg::op_ctrl_t ctrl;

    always_comb begin
        ctrl.mul_a = t_reg[31:0];
        ctrl.mul_b = asum_reg[31:0];
        ctrl.shift = prs_pkg::SH_0;
        ctrl.clear = 1'b0;
        ctrl.to_t  = 1'b0;
        ctrl.succ  = prs_pkg::OP_P;
        case (op_reg)
            prs_pkg::OP_P: begin
                ctrl.mul_a = akp_reg;
                ctrl.mul_b = ae_reg;
                ctrl.clear = 1'b1;
                ctrl.succ  = prs_pkg::OP_KI_IV;
            end
            prs_pkg::OP_KI_IV: begin
                ctrl.mul_a = aki_reg;
                ctrl.mul_b = {8'b0, iv_reg};
                ctrl.to_t  = 1'b1;
                ctrl.succ  = prs_pkg::OP_I_00;
            end
            prs_pkg::OP_I_00: begin
                ctrl.mul_a = t_reg[31:0];
                ctrl.mul_b = asum_reg[31:0];
                ctrl.clear = 1'b1;
                ctrl.succ  = prs_pkg::OP_I_01;
            end
            prs_pkg::OP_I_01: begin
                ctrl.mul_a = t_reg[31:0];
                ctrl.mul_b = {16'b0, asum_reg[47:32]};
                ctrl.shift = prs_pkg::SH_32;
                ctrl.succ  = prs_pkg::OP_I_10;
            end
            prs_pkg::OP_I_10: begin
                ctrl.mul_a = {8'b0, t_reg[55:32]};
                ctrl.mul_b = asum_reg[31:0];
                ctrl.shift = prs_pkg::SH_32;
                ctrl.succ  = prs_pkg::OP_I_11;
            end
            prs_pkg::OP_I_11: begin
                ctrl.mul_a = {8'b0, t_reg[55:32]};
                ctrl.mul_b = {16'b0, asum_reg[47:32]};
                ctrl.shift = prs_pkg::SH_64;
                ctrl.succ  = prs_pkg::OP_KD_US;
            end
            prs_pkg::OP_KD_US: begin
                ctrl.mul_a = akd_reg;
                ctrl.mul_b = {8'b0, prs_pkg::MICROS_PER_SEC};
                ctrl.to_t  = 1'b1;
                ctrl.succ  = prs_pkg::OP_D_0;
            end
            prs_pkg::OP_D_0: begin
                ctrl.mul_a = t_reg[31:0];
                ctrl.mul_b = adiff_reg;
                ctrl.clear = 1'b1;
                ctrl.succ  = prs_pkg::OP_D_1;
            end
            prs_pkg::OP_D_1: begin
                ctrl.mul_a = {8'b0, t_reg[55:32]};
                ctrl.mul_b = adiff_reg;
                ctrl.shift = prs_pkg::SH_32;
                ctrl.succ  = prs_pkg::OP_P;
            end
            default: ;
        endcase
    end

    // accumulator add of the shifted partial product
    logic [103:0] acc_add;
    logic [103:0] acc_next;

    always_comb begin
        case (ctrl.shift)
            prs_pkg::SH_0:  acc_add = {40'b0, prod_reg};
            prs_pkg::SH_32: acc_add = {8'b0, prod_reg, 32'b0};
            prs_pkg::SH_64: acc_add = {prod_reg[39:0], 64'b0};
            default:        acc_add = {40'b0, prod_reg};
        endcase
        acc_next = (ctrl.clear ? 104'b0 : acc_reg) + acc_add;
    end

    // four restoring division steps per cycle
    logic [23:0] rem_next;
    logic [3:0]  qbits;

    always_comb begin
        logic [23:0] r;
        logic [24:0] trial;
        r     = rem_reg;
        qbits = '0;
        for (int k = 0; k < 4; k++) begin
            trial = {r, num_reg[63-k]};
            if (trial >= {1'b0, div_d_reg}) begin
                trial        = trial - {1'b0, div_d_reg};
                qbits[3-k]   = 1'b1;
            end
            r = trial[23:0];
        end
        rem_next = r;
    end

    // rounded, clamped, signed term
    logic               round_up;
    logic        [61:0] term_mag;
    logic               term_neg;
    logic signed [63:0] term_s;
    logic signed [63:0] total_next;
    logic signed [31:0] drive_next;

    always_comb begin
        round_up = (({rem_reg, 1'b0} + {24'b0, low_reg}) >= {1'b0, div_d_reg});
        if (op_reg == prs_pkg::OP_P) begin
            term_mag = acc_reg[77:16] + {61'b0, acc_reg[15]};
        end else if (ovf_reg) begin
            term_mag = prs_pkg::TERM_CLAMP;
        end else begin
            term_mag = quot_reg[61:0] + {61'b0, round_up};
        end
        case (op_reg)
            prs_pkg::OP_P:    term_neg = neg_p_reg;
            prs_pkg::OP_I_11: term_neg = neg_i_reg;
            default:          term_neg = neg_d_reg;
        endcase
        term_s     = term_neg ? -$signed({2'b0, term_mag}) : $signed({2'b0, term_mag});
        total_next = total_reg + term_s;
        if (total_reg[63:31] == '0 || total_reg[63:31] == '1) begin
            drive_next = total_reg[31:0];
        end else begin
            drive_next = total_reg[63] ? prs_pkg::DRIVE_NEG_MAX : prs_pkg::DRIVE_POS_MAX;
        end
    end

    // sequencer, regulator state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            op_reg         <= prs_pkg::OP_P;
            div_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            last_drive_reg <= '0;
        end else begin
            // result taken; a finishing item reloads the output register itself
            if (m_valid_reg && m_ready && state_reg != ST_FIN) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        meas_reg  <= s_measured;
                        state_reg <= ST_ERR;
                    end
                end
                ST_ERR: begin
                    e_reg         <= e_next;
                    inband_reg    <= inband_next;
                    windup_ok_reg <= (last_drive_reg > drive_min_reg) &&
                                     (last_drive_reg < drive_max_reg);
                    state_reg     <= ST_SUM;
                end
                ST_SUM: begin
                    if (windup_ok_reg) begin
                        error_sum_reg <= sum_next;
                    end
                    diff_reg  <= diff_next;
                    state_reg <= ST_MAG;
                end
                ST_MAG: begin
                    // magnitudes and term signs
                    akp_reg   <= gain_prop_reg[31]  ? 32'(-gain_prop_reg)  : gain_prop_reg;
                    aki_reg   <= gain_integ_reg[31] ? 32'(-gain_integ_reg) : gain_integ_reg;
                    akd_reg   <= gain_deriv_reg[31] ? 32'(-gain_deriv_reg) : gain_deriv_reg;
                    ae_reg    <= e_reg[31] ? 32'(-e_reg) : e_reg;
                    asum_reg  <= error_sum_reg[47] ? 48'(-error_sum_reg) : error_sum_reg;
                    adiff_reg <= diff_reg[32] ? 32'(-diff_reg) : diff_reg[31:0];
                    iv_reg    <= (interval_us_reg == '0) ? 24'd1 : interval_us_reg;
                    neg_p_reg <= gain_prop_reg[31]  != e_reg[31];
                    neg_i_reg <= gain_integ_reg[31] != error_sum_reg[47];
                    neg_d_reg <= gain_deriv_reg[31] != diff_reg[32];
                    total_reg <= '0;
                    op_reg    <= prs_pkg::OP_P;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= ctrl.mul_a * ctrl.mul_b;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    if (ctrl.to_t) begin
                        t_reg <= prod_reg[55:0];
                    end else begin
                        acc_reg <= acc_next;
                    end
                    case (op_reg)
                        prs_pkg::OP_P: begin
                            state_reg <= ST_TERM;
                        end
                        prs_pkg::OP_I_11: begin
                            div_d_reg <= prs_pkg::MICROS_PER_SEC;
                            state_reg <= ST_DIV_INIT;
                        end
                        prs_pkg::OP_D_1: begin
                            div_d_reg <= iv_reg;
                            state_reg <= ST_DIV_INIT;
                        end
                        default: begin
                            op_reg    <= ctrl.succ;
                            state_reg <= ST_MUL;
                        end
                    endcase
                end
                ST_DIV_INIT: begin
                    // quotient of 2^61 or more clamps; else the top bits start below the divisor
                    ovf_reg     <= (acc_reg[103:77] >= {3'b0, div_d_reg});
                    rem_reg     <= acc_reg[103:80];
                    num_reg     <= acc_reg[79:16];
                    low_reg     <= acc_reg[15];
                    quot_reg    <= '0;
                    div_cnt_reg <= '0;
                    state_reg   <= (acc_reg[103:77] >= {3'b0, div_d_reg}) ? ST_TERM : ST_DIV;
                end
                ST_DIV: begin
                    rem_reg     <= rem_next;
                    num_reg     <= {num_reg[59:0], 4'b0};
                    quot_reg    <= {quot_reg[59:0], qbits};
                    div_cnt_reg <= div_cnt_reg + 4'd1;
                    if (div_cnt_reg == 4'd15) begin
                        state_reg <= ST_TERM;
                    end
                end
                ST_TERM: begin
                    total_reg <= total_next;
                    case (op_reg)
                        prs_pkg::OP_P: begin
                            op_reg    <= ctrl.succ;
                            state_reg <= ST_MUL;
                        end
                        prs_pkg::OP_I_11: begin
                            op_reg    <= ctrl.succ;
                            state_reg <= ST_MUL;
                        end
                        default: begin
                            state_reg <= ST_FIN;
                        end
                    endcase
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        drive_reg      <= drive_next;
                        out_inband_reg <= inband_reg;
                        m_valid_reg    <= 1'b1;
                        last_drive_reg <= drive_next;
                        last_error_reg <= e_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // partial remainder stays below the divisor while dividing
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < div_d_reg))
        else $error("partial remainder not below divisor");

    // the divide counter only runs inside the divide loop
    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_DIV) |-> (div_cnt_reg == 4'd0))
        else $error("divide counter active outside divide loop");

    // a quotient that did not clamp is below 2^61
    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TERM && op_reg != prs_pkg::OP_P && !ovf_reg)
        |-> (quot_reg[63:61] == 3'b000))
        else $error("unclamped quotient out of range");

    // a deadband hit always leaves a zero error
    a_band_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM && inband_reg) |-> (e_reg == '0))
        else $error("deadband item with nonzero error");

    // the delivered drive is the drive kept for anti-windup
    a_last_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && (!m_valid_reg || m_ready))
        |=> (m_valid && last_drive_reg == m_drive))
        else $error("last drive does not match delivered drive");

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for pid_regulator_step: directed items, then random phases.
// A fixed-point predictor inside the bench computes each expected drive item.
// Depends on prs_pkg and the pid_regulator_step RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam int unsigned NUM_REGS     = 8;
    localparam int unsigned MAX_SHOWN    = 10;
    localparam int unsigned NUM_PHASES   = 15;
    localparam int unsigned PHASE_ITEMS  = 48;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned TAIL_CYCLES  = 100;

    // 1e6 * 2^16, divisor of the integral term
    localparam logic [127:0] INTEG_DIVISOR = 128'd65536000000;

    localparam logic signed [33:0] ERR_HI   = 34'sd2147483647;
    localparam logic signed [33:0] ERR_LO   = -34'sd2147483648;
    localparam logic signed [48:0] SUM_HI   = 49'sd140737488355327;
    localparam logic signed [48:0] SUM_LO   = -49'sd140737488355328;
    localparam logic signed [65:0] DRIVE_HI = 66'sd2147483647;
    localparam logic signed [65:0] DRIVE_LO = -66'sd2147483648;

    typedef logic [prs_pkg::CFG_INDEX_W-1:0] cfg_index_t;

    typedef struct packed {
        logic [31:0] drive;
        logic        in_deadband;
    } drive_item_t;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_index_t             cfg_index = '0;
    logic [31:0]            cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic signed [31:0]     s_measured = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic signed [31:0]     m_drive;
    logic                   m_in_deadband;

    // Predictor copy of registers and state
    logic signed [31:0] kp_cfg, ki_cfg, kd_cfg, setpoint_cfg;
    logic signed [31:0] drive_min_cfg, drive_max_cfg;
    logic [23:0]        interval_cfg;
    logic [30:0]        deadband_cfg;
    logic signed [47:0] integ_sum;
    logic signed [31:0] prev_error, prev_drive;

    drive_item_t drive_expected[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          idle_on = 1'b1;
    int unsigned hold_request = 0;

    pid_regulator_step dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_measured    (s_measured),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_drive       (m_drive),
        .m_in_deadband (m_in_deadband)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog
    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        return x[31] ? -x : x;
    endfunction

    // round(num/den), ties away from zero, magnitude clamped, then signed
    function automatic logic signed [65:0] round_term(input logic [127:0] num,
                                                      input logic [127:0] den,
                                                      input logic neg);
        logic [127:0] quo;
        logic [127:0] rem;
        quo = num / den;
        rem = num % den;
        if (quo >= prs_pkg::TERM_CLAMP) begin
            quo = prs_pkg::TERM_CLAMP;
        end else if ((rem << 1) >= den) begin
            quo = quo + 1;
        end
        return neg ? -$signed({2'b00, quo[63:0]}) : $signed({2'b00, quo[63:0]});
    endfunction

    // One regulation step: updates predictor state, returns the drive item
    function automatic drive_item_t pid_predict(input logic signed [31:0] meas);
        logic signed [33:0] err_wide;
        logic [33:0]        err_abs;
        logic               in_band;
        logic signed [31:0] err;
        logic signed [48:0] sum_next;
        logic signed [32:0] diff;
        logic [23:0]        iv;
        logic [127:0]       num;
        logic [127:0]       den;
        logic [127:0]       part_abs;
        logic signed [65:0] term_p, term_i, term_d, total;
        drive_item_t        res;

        iv = (interval_cfg == 24'd0) ? 24'd1 : interval_cfg;

        // exact error, deadband on the exact value, then saturate
        err_wide = setpoint_cfg;
        err_wide = err_wide - meas;
        err_abs = err_wide[33] ? -err_wide : err_wide;
        in_band = err_abs < {3'b000, deadband_cfg};
        if (in_band) begin
            err_wide = '0;
        end
        if (err_wide > ERR_HI) begin
            err = prs_pkg::DRIVE_POS_MAX;
        end else if (err_wide < ERR_LO) begin
            err = prs_pkg::DRIVE_NEG_MAX;
        end else begin
            err = err_wide[31:0];
        end

        // anti-windup: integrate only while the last drive is inside the limits
        if (prev_drive > drive_min_cfg && prev_drive < drive_max_cfg) begin
            sum_next = integ_sum;
            sum_next = sum_next + err;
            if (sum_next > SUM_HI) begin
                integ_sum = prs_pkg::SUM_POS_MAX;
            end else if (sum_next < SUM_LO) begin
                integ_sum = prs_pkg::SUM_NEG_MAX;
            end else begin
                integ_sum = sum_next[47:0];
            end
        end

        num = mag32(kp_cfg);
        num = num * mag32(err);
        term_p = round_term(num, 128'd65536, kp_cfg[31] != err[31]);

        part_abs = integ_sum[47] ? -integ_sum : integ_sum;
        num = mag32(ki_cfg);
        num = num * iv;
        num = num * part_abs;
        term_i = round_term(num, INTEG_DIVISOR, ki_cfg[31] != integ_sum[47]);

        diff = err;
        diff = diff - prev_error;
        part_abs = diff[32] ? -diff : diff;
        num = mag32(kd_cfg);
        num = num * prs_pkg::MICROS_PER_SEC;
        num = num * part_abs;
        den = iv;
        den = den << 16;
        term_d = round_term(num, den, kd_cfg[31] != diff[32]);

        total = term_p + term_i + term_d;
        if (total > DRIVE_HI) begin
            res.drive = prs_pkg::DRIVE_POS_MAX;
        end else if (total < DRIVE_LO) begin
            res.drive = prs_pkg::DRIVE_NEG_MAX;
        end else begin
            res.drive = total[31:0];
        end
        res.in_deadband = in_band;
        prev_drive = res.drive;
        prev_error = err;
        return res;
    endfunction

    task automatic flag_error(input string text);
        error_count++;
        if (error_count <= MAX_SHOWN) begin
            $display("%0t: %s", $time, text);
        end
    endtask

    // Scoreboard: check results, follow register writes, predict accepted items
    always @(posedge aclk) begin : scoreboard
        drive_item_t want;
        if (!aresetn) begin
            kp_cfg        = '0;
            ki_cfg        = '0;
            kd_cfg        = '0;
            interval_cfg  = 24'd1;
            setpoint_cfg  = '0;
            deadband_cfg  = '0;
            drive_min_cfg = prs_pkg::DRIVE_NEG_MAX;
            drive_max_cfg = prs_pkg::DRIVE_POS_MAX;
            integ_sum     = '0;
            prev_error    = '0;
            prev_drive    = '0;
        end else begin
            if (m_valid === 1'b1 && m_ready) begin
                if (drive_expected.size() == 0) begin
                    flag_error($sformatf("unexpected item: drive %h deadband %b",
                                         m_drive, m_in_deadband));
                end else begin
                    want = drive_expected.pop_front();
                    if (m_drive !== want.drive || m_in_deadband !== want.in_deadband) begin
                        flag_error($sformatf(
                            "mismatch: expected drive %h deadband %b, got drive %h deadband %b",
                            want.drive, want.in_deadband, m_drive, m_in_deadband));
                    end
                end
            end
            if (cfg_valid && cfg_ready === 1'b1) begin
                case (cfg_index)
                    prs_pkg::CFG_GAIN_PROP:   kp_cfg = cfg_data;
                    prs_pkg::CFG_GAIN_INTEG:  ki_cfg = cfg_data;
                    prs_pkg::CFG_GAIN_DERIV:  kd_cfg = cfg_data;
                    prs_pkg::CFG_INTERVAL_US: interval_cfg = cfg_data[23:0];
                    prs_pkg::CFG_SETPOINT:    setpoint_cfg = cfg_data;
                    prs_pkg::CFG_DEADBAND:    deadband_cfg = cfg_data[30:0];
                    prs_pkg::CFG_DRIVE_MIN:   drive_min_cfg = cfg_data;
                    prs_pkg::CFG_DRIVE_MAX:   drive_max_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready === 1'b1) begin
                drive_expected.push_back(pid_predict(s_measured));
            end
        end
    end

    // Result sink: random stall per item, or a long hold when requested
    initial begin : drive_sink
        int unsigned stall;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_request != 0) begin
                stall = hold_request;
                hold_request = 0;
            end else begin
                stall = idle_on ? $urandom_range(0, 4) : 0;
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    // Offer one measured item; returns at the edge it was accepted
    task automatic send_measured(input logic [31:0] value);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_measured <= value;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    // Drop valid and wait until every expected item has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (drive_expected.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_gain();
        logic [31:0] g;
        case ($urandom_range(0, 7))
            0: g = 32'h8000_0000;
            1: g = 32'h7fff_ffff;
            2: g = '0;
            3: g = $urandom();
            default: begin
                g = $urandom_range(0, 32'h0004_0000);
                if ($urandom_range(0, 1) == 1) begin
                    g = -g;
                end
            end
        endcase
        return g;
    endfunction

    // Mostly near the setpoint, sometimes anywhere or at the extremes
    function automatic logic [31:0] pick_measured(input logic [31:0] center);
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            default: return center + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    // Reset values: all gains zero, drive always zero
    task automatic test_defaults();
        send_measured(32'h8000_0000);
        send_measured(32'h7fff_ffff);
    endtask

    // Error saturation both ways, and rounding of half values away from zero
    task automatic test_proportional();
        write_reg(prs_pkg::CFG_GAIN_PROP, 32'h7fff_ffff);
        write_reg(prs_pkg::CFG_SETPOINT, 32'h7fff_ffff);
        send_measured(32'h8000_0000);
        write_reg(prs_pkg::CFG_SETPOINT, 32'h8000_0000);
        send_measured(32'h7fff_ffff);
        write_reg(prs_pkg::CFG_GAIN_PROP, 32'h0000_8000);
        write_reg(prs_pkg::CFG_SETPOINT, 32'h0000_0000);
        send_measured(32'hffff_ffff);
        send_measured(32'h0000_0001);
    endtask

    // Just inside, on the edge, and the widest band (top data bit dropped)
    task automatic test_deadband();
        write_reg(prs_pkg::CFG_GAIN_PROP, 32'h0001_0000);
        write_reg(prs_pkg::CFG_DEADBAND, 32'h0000_0100);
        send_measured(32'h0000_00ff);
        send_measured(32'hffff_ff00);
        write_reg(prs_pkg::CFG_DEADBAND, 32'hffff_ffff);
        send_measured(32'h0000_0001);
        send_measured(32'h8000_0000);
    endtask

    // Integration, freeze at the upper limit, and crossed limits
    task automatic test_integral();
        write_reg(prs_pkg::CFG_DEADBAND, 32'h0000_0000);
        write_reg(prs_pkg::CFG_GAIN_PROP, 32'h0000_0000);
        write_reg(prs_pkg::CFG_GAIN_INTEG, 32'h0001_0000);
        write_reg(prs_pkg::CFG_INTERVAL_US, {8'h00, prs_pkg::MICROS_PER_SEC});
        write_reg(prs_pkg::CFG_SETPOINT, 32'h0001_0000);
        send_measured(32'h0000_0000);
        send_measured(32'h0000_0000);
        write_reg(prs_pkg::CFG_DRIVE_MAX, 32'h0001_0000);
        send_measured(32'h0000_0000);
        write_reg(prs_pkg::CFG_DRIVE_MIN, 32'h0000_0100);
        write_reg(prs_pkg::CFG_DRIVE_MAX, 32'hffff_ff00);
        send_measured(32'h0000_0000);
    endtask

    // Zero interval counts as one microsecond; longest interval
    task automatic test_derivative();
        write_reg(prs_pkg::CFG_DRIVE_MIN, 32'h8000_0000);
        write_reg(prs_pkg::CFG_DRIVE_MAX, 32'h7fff_ffff);
        write_reg(prs_pkg::CFG_GAIN_INTEG, 32'h0000_0000);
        write_reg(prs_pkg::CFG_GAIN_DERIV, 32'h0001_0000);
        write_reg(prs_pkg::CFG_INTERVAL_US, 32'h0000_0000);
        write_reg(prs_pkg::CFG_SETPOINT, 32'h0000_0000);
        send_measured(32'hffff_ff00);
        send_measured(32'h0000_0100);
        write_reg(prs_pkg::CFG_INTERVAL_US, 32'hffff_ffff);
        send_measured(32'h7fff_ffff);
    endtask

    // Derivative term far beyond the term clamp, against a large P term
    task automatic test_huge_terms();
        write_reg(prs_pkg::CFG_GAIN_PROP, 32'h7fff_ffff);
        write_reg(prs_pkg::CFG_GAIN_DERIV, 32'h8000_0000);
        write_reg(prs_pkg::CFG_INTERVAL_US, 32'h0000_0001);
        send_measured(32'h8000_0000);
        send_measured(32'h7fff_ffff);
    endtask

    // Writes above the last register must change nothing
    task automatic test_unknown_register();
        write_reg(cfg_index_t'(NUM_REGS), $urandom());
        write_reg(cfg_index_t'(2 ** prs_pkg::CFG_INDEX_W - 1), $urandom());
        send_measured($urandom());
    endtask

    // Sink holds off while the source keeps offering, so the block stalls its input
    task automatic test_backpressure();
        wait_idle();
        hold_request = HOLD_CYCLES;
        repeat (12) send_measured(pick_measured(setpoint_cfg));
    endtask

    // Random register settings per phase, random items within each phase
    task automatic test_random();
        logic [31:0] sp;
        logic [31:0] iv;
        logic [31:0] band;
        logic [31:0] lo;
        logic [31:0] hi;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case ($urandom_range(0, 5))
                0: iv = 32'h0000_0000;
                1: iv = 32'h0000_0001;
                2: iv = 32'h00ff_ffff;
                3: iv = $urandom();
                default: iv = $urandom_range(100, 1000000);
            endcase
            case ($urandom_range(0, 4))
                0: sp = 32'h8000_0000;
                1: sp = 32'h7fff_ffff;
                2: sp = $urandom();
                default: sp = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            endcase
            case ($urandom_range(0, 5))
                0, 1: band = 32'h0000_0000;
                2: band = 32'hffff_ffff;
                3: band = $urandom();
                default: band = $urandom_range(0, 32'h0000_4000);
            endcase
            case ($urandom_range(0, 4))
                0: begin
                    lo = 32'h8000_0000;
                    hi = 32'h7fff_ffff;
                end
                1: begin
                    lo = $urandom_range(0, 32'h0010_0000);
                    hi = lo - $urandom_range(0, 32'h0010_0000);
                end
                2: begin
                    lo = $urandom();
                    hi = $urandom();
                end
                default: begin
                    lo = -$urandom_range(32'h0001_0000, 32'h0040_0000);
                    hi = $urandom_range(32'h0001_0000, 32'h0040_0000);
                end
            endcase
            write_reg(prs_pkg::CFG_GAIN_PROP, pick_gain());
            write_reg(prs_pkg::CFG_GAIN_INTEG, pick_gain());
            write_reg(prs_pkg::CFG_GAIN_DERIV, pick_gain());
            write_reg(prs_pkg::CFG_INTERVAL_US, iv);
            write_reg(prs_pkg::CFG_SETPOINT, sp);
            write_reg(prs_pkg::CFG_DEADBAND, band);
            write_reg(prs_pkg::CFG_DRIVE_MIN, lo);
            write_reg(prs_pkg::CFG_DRIVE_MAX, hi);
            if ($urandom_range(0, 3) == 0) begin
                write_reg(cfg_index_t'($urandom_range(NUM_REGS, 2 ** prs_pkg::CFG_INDEX_W - 1)),
                          $urandom());
            end
            // every fourth phase runs without any idle cycles
            idle_on = (phase % 4) != 3;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_measured(pick_measured(sp));
            end
            idle_on = 1'b1;
        end
    endtask

    initial begin : run
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_defaults();
        test_proportional();
        test_deadband();
        test_integral();
        test_derivative();
        test_huge_terms();
        test_unknown_register();
        test_backpressure();
        test_random();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
rtl/prs_pkg.sv
rtl/pid_regulator_step.sv
tb/tb_top.sv
